[sv/hse_pkg.sv]
// Shared constants, state and command types for the heap sort engine.
package hse_pkg;

   localparam int DEPTH  = 64;
   localparam int DATA_W = 32;
   localparam int POS_W  = $clog2(DEPTH + 1);
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int MODE_W = 2;
   localparam int CSR_AW = 3;
   localparam int CSR_DW = 32;
   localparam int REG_W  = CSR_AW - 2;

   localparam logic [MODE_W-1:0] MODE_SORT = MODE_W'(0);
   localparam logic [MODE_W-1:0] MODE_MAX  = MODE_W'(1);
   localparam logic [MODE_W-1:0] MODE_MIN  = MODE_W'(2);

   localparam logic [REG_W-1:0] REG_MODE = REG_W'(0);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_BUILD_INIT,
      ST_BUILD_NEXT,
      ST_NODE_LD,
      ST_SIFT_CHK,
      ST_CMP_L,
      ST_CMP_R,
      ST_MOVE,
      ST_SIFT_END,
      ST_SORT_NEXT,
      ST_TOP_LD,
      ST_BOT_LD,
      ST_EMIT_RD,
      ST_EMIT_LD
   } hse_state_type;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_LOAD,
      OP_BUILD_INIT,
      OP_NODE_RD,
      OP_NODE_LD,
      OP_CHILD_L,
      OP_CMP_L,
      OP_CMP_R,
      OP_MOVE,
      OP_SIFT_END,
      OP_SORT_INIT,
      OP_TOP_RD,
      OP_TOP_LD,
      OP_BOT_LD,
      OP_EMIT_INIT,
      OP_EMIT_RD,
      OP_EMIT_LD
   } hse_op_type;

   typedef struct packed {
      logic sort_mode;
      logic kcnt_zero;
      logic kcnt_lt2;
      logic lc_ok;
      logic rc_ok;
      logic best_is_node;
      logic p_last;
      logic out_free;
   } hse_stat_type;

endpackage

[sv/hse_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module hse_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/hse_ctrl.sv]
// Sequencer that steps the datapath through load, heap build, sort (in sort mode only) and emit.
module hse_ctrl
   import hse_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_last,
   output logic         req_ready,
   input  hse_stat_type stat,
   output hse_op_type   op
);

   hse_state_type state_ff, state_in;
   logic          sorting_ff, sorting_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         sorting_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         sorting_ff <= sorting_in;
      end
   end

   // Next state.
   always_comb begin
      state_in   = state_ff;
      sorting_in = sorting_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_last) begin
               state_in = ST_BUILD_INIT;
            end
         end
         ST_BUILD_INIT: begin
            sorting_in = 1'b0;
            state_in   = ST_BUILD_NEXT;
         end
         ST_BUILD_NEXT: begin
            if (!stat.kcnt_zero) begin
               state_in = ST_NODE_LD;
            end else if (stat.sort_mode) begin
               sorting_in = 1'b1;
               state_in   = ST_SORT_NEXT;
            end else begin
               state_in = ST_EMIT_RD;
            end
         end
         ST_NODE_LD:  state_in = ST_SIFT_CHK;
         ST_SIFT_CHK: state_in = stat.lc_ok ? ST_CMP_L : ST_SIFT_END;
         ST_CMP_L:    state_in = stat.rc_ok ? ST_CMP_R : ST_MOVE;
         ST_CMP_R:    state_in = ST_MOVE;
         ST_MOVE:     state_in = stat.best_is_node ? ST_SIFT_END : ST_SIFT_CHK;
         ST_SIFT_END: state_in = sorting_ff ? ST_SORT_NEXT : ST_BUILD_NEXT;
         ST_SORT_NEXT: state_in = stat.kcnt_lt2 ? ST_EMIT_RD : ST_TOP_LD;
         ST_TOP_LD:   state_in = ST_BOT_LD;
         ST_BOT_LD:   state_in = ST_SIFT_CHK;
         ST_EMIT_RD: begin
            if (stat.out_free) begin
               state_in = ST_EMIT_LD;
            end
         end
         ST_EMIT_LD:  state_in = stat.p_last ? ST_IDLE : ST_EMIT_RD;
         default:     state_in = ST_IDLE;
      endcase
   end

   // Outputs.
   always_comb begin
      op        = OP_NONE;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op = OP_LOAD;
            end
         end
         ST_BUILD_INIT: op = OP_BUILD_INIT;
         ST_BUILD_NEXT: begin
            if (!stat.kcnt_zero) begin
               op = OP_NODE_RD;
            end else if (stat.sort_mode) begin
               op = OP_SORT_INIT;
            end else begin
               op = OP_EMIT_INIT;
            end
         end
         ST_NODE_LD: op = OP_NODE_LD;
         ST_SIFT_CHK: begin
            if (stat.lc_ok) begin
               op = OP_CHILD_L;
            end
         end
         ST_CMP_L: op = OP_CMP_L;
         ST_CMP_R: op = OP_CMP_R;
         ST_MOVE: begin
            if (!stat.best_is_node) begin
               op = OP_MOVE;
            end
         end
         ST_SIFT_END: op = OP_SIFT_END;
         ST_SORT_NEXT: op = stat.kcnt_lt2 ? OP_EMIT_INIT : OP_TOP_RD;
         ST_TOP_LD: op = OP_TOP_LD;
         ST_BOT_LD: op = OP_BOT_LD;
         ST_EMIT_RD: begin
            if (stat.out_free) begin
               op = OP_EMIT_RD;
            end
         end
         ST_EMIT_LD: op = OP_EMIT_LD;
         default: op = OP_NONE;
      endcase
   end

endmodule

[sv/hse_dp.sv]
// Datapath: counters, sift registers, comparator, mode register and result register.
module hse_dp
   import hse_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  hse_op_type               op,
   input  logic signed [DATA_W-1:0] req_value,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_AW-1:0]        paddr,
   input  logic [CSR_DW-1:0]        pwdata,
   output logic [CSR_DW-1:0]        prdata,
   output logic                     pready,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [DATA_W-1:0] rsp_value_res,
   output logic                     rsp_last_res,
   output logic                     rsp_overflow,
   output logic                     ram_wr_en,
   output logic [ADDR_W-1:0]        ram_wr_addr,
   output logic [DATA_W-1:0]        ram_wr_data,
   output logic                     ram_rd_en,
   output logic [ADDR_W-1:0]        ram_rd_addr,
   input  logic signed [DATA_W-1:0] ram_rd_data,
   output hse_stat_type             stat
);

   localparam logic [POS_W-1:0] ONE_POS   = POS_W'(1);
   localparam logic [POS_W-1:0] TWO_POS   = POS_W'(2);
   localparam logic [POS_W-1:0] DEPTH_POS = POS_W'(DEPTH);
   localparam logic [POS_W:0]   ONE_RP    = (POS_W + 1)'(1);

   // Control state.
   logic [POS_W-1:0]  loaded_ff, loaded_in;
   logic [POS_W-1:0]  extent_ff, extent_in;
   logic              dropped_ff, dropped_in;
   logic [MODE_W-1:0] mode_ff, mode_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // Working registers.
   logic [POS_W-1:0]         kcnt_ff, kcnt_in;
   logic [POS_W-1:0]         i_ff, i_in;
   logic [POS_W-1:0]         bidx_ff, bidx_in;
   logic [POS_W-1:0]         p_ff, p_in;
   logic signed [DATA_W-1:0] v_ff, v_in;
   logic signed [DATA_W-1:0] best_ff, best_in;
   logic signed [DATA_W-1:0] rsp_value_ff, rsp_value_in;
   logic                     rsp_last_ff, rsp_last_in;
   logic                     rsp_ovf_ff, rsp_ovf_in;

   logic [POS_W:0] lc;
   logic [POS_W:0] rc;
   logic [POS_W:0] rd_pos;
   logic           want_max;
   logic           better;
   logic           full;
   logic           csr_wr;
   logic [REG_W-1:0] reg_idx;

   always_ff @(posedge clock) begin
      if (reset) begin
         loaded_ff    <= '0;
         extent_ff    <= '0;
         dropped_ff   <= 1'b0;
         mode_ff      <= MODE_SORT;
         rsp_valid_ff <= 1'b0;
      end else begin
         loaded_ff    <= loaded_in;
         extent_ff    <= extent_in;
         dropped_ff   <= dropped_in;
         mode_ff      <= mode_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kcnt_ff      <= kcnt_in;
      i_ff         <= i_in;
      bidx_ff      <= bidx_in;
      p_ff         <= p_in;
      v_ff         <= v_in;
      best_ff      <= best_in;
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   assign lc       = {i_ff, 1'b0};
   assign rc       = {i_ff, 1'b1};
   assign want_max = (mode_ff != MODE_MIN);
   assign better   = want_max ? (ram_rd_data > best_ff) : (ram_rd_data < best_ff);
   assign full     = (loaded_ff == DEPTH_POS);

   // Configuration port.
   assign reg_idx = paddr[CSR_AW-1:2];
   assign csr_wr  = psel && penable && pwrite;
   assign pready  = 1'b1;
   assign prdata  = (reg_idx == REG_MODE) ? CSR_DW'(mode_ff) : '0;

   always_comb begin
      mode_in = mode_ff;
      if (csr_wr && (reg_idx == REG_MODE)) begin
         mode_in = pwdata[MODE_W-1:0];
      end
   end

   always_comb begin
      loaded_in    = loaded_ff;
      extent_in    = extent_ff;
      dropped_in   = dropped_ff;
      kcnt_in      = kcnt_ff;
      i_in         = i_ff;
      bidx_in      = bidx_ff;
      p_in         = p_ff;
      v_in         = v_ff;
      best_in      = best_ff;
      rsp_value_in = rsp_value_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = '0;
      ram_wr_data  = '0;
      ram_rd_en    = 1'b0;
      rd_pos       = ONE_RP;
      case (op)
         OP_LOAD: begin
            if (!full) begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = loaded_ff[ADDR_W-1:0];
               ram_wr_data = req_value;
               loaded_in   = loaded_ff + ONE_POS;
            end else begin
               dropped_in = 1'b1;
            end
         end
         OP_BUILD_INIT: begin
            extent_in = loaded_ff;
            kcnt_in   = loaded_ff >> 1;
         end
         OP_NODE_RD: begin
            ram_rd_en = 1'b1;
            rd_pos    = {1'b0, kcnt_ff};
            i_in      = kcnt_ff;
         end
         OP_NODE_LD: begin
            v_in    = ram_rd_data;
            best_in = ram_rd_data;
            bidx_in = i_ff;
         end
         OP_CHILD_L: begin
            ram_rd_en = 1'b1;
            rd_pos    = lc;
         end
         OP_CMP_L: begin
            if (better) begin
               best_in = ram_rd_data;
               bidx_in = lc[POS_W-1:0];
            end
            if (stat.rc_ok) begin
               ram_rd_en = 1'b1;
               rd_pos    = rc;
            end
         end
         OP_CMP_R: begin
            if (better) begin
               best_in = ram_rd_data;
               bidx_in = rc[POS_W-1:0];
            end
         end
         OP_MOVE: begin
            // The larger (or smaller) child moves up; the carried key follows it down.
            ram_wr_en   = 1'b1;
            ram_wr_addr = ADDR_W'(i_ff - ONE_POS);
            ram_wr_data = best_ff;
            i_in        = bidx_ff;
            best_in     = v_ff;
         end
         OP_SIFT_END: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = ADDR_W'(i_ff - ONE_POS);
            ram_wr_data = v_ff;
            kcnt_in     = kcnt_ff - ONE_POS;
         end
         OP_SORT_INIT: begin
            kcnt_in = loaded_ff;
         end
         OP_TOP_RD: begin
            ram_rd_en = 1'b1;
            rd_pos    = ONE_RP;
         end
         OP_TOP_LD: begin
            best_in   = ram_rd_data;
            ram_rd_en = 1'b1;
            rd_pos    = {1'b0, kcnt_ff};
         end
         OP_BOT_LD: begin
            // Root goes to the tail; the old tail key sifts down from the root.
            ram_wr_en   = 1'b1;
            ram_wr_addr = ADDR_W'(kcnt_ff - ONE_POS);
            ram_wr_data = best_ff;
            v_in        = ram_rd_data;
            best_in     = ram_rd_data;
            bidx_in     = ONE_POS;
            i_in        = ONE_POS;
            extent_in   = extent_ff - ONE_POS;
         end
         OP_EMIT_INIT: begin
            p_in = ONE_POS;
         end
         OP_EMIT_RD: begin
            ram_rd_en = 1'b1;
            rd_pos    = {1'b0, p_ff};
         end
         OP_EMIT_LD: begin
            rsp_valid_in = 1'b1;
            rsp_value_in = ram_rd_data;
            rsp_last_in  = stat.p_last;
            rsp_ovf_in   = dropped_ff;
            if (stat.p_last) begin
               loaded_in  = '0;
               dropped_in = 1'b0;
            end else begin
               p_in = p_ff + ONE_POS;
            end
         end
         default: begin
         end
      endcase
   end

   assign ram_rd_addr = ADDR_W'(rd_pos - ONE_RP);

   assign stat.sort_mode    = (mode_ff != MODE_MAX) && (mode_ff != MODE_MIN);
   assign stat.kcnt_zero    = (kcnt_ff == '0);
   assign stat.kcnt_lt2     = (kcnt_ff < TWO_POS);
   assign stat.lc_ok        = (lc <= {1'b0, extent_ff});
   assign stat.rc_ok        = (rc <= {1'b0, extent_ff});
   assign stat.best_is_node = (bidx_ff == i_ff);
   assign stat.p_last       = (p_ff == loaded_ff);
   assign stat.out_free     = !rsp_valid_ff || rsp_ready;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_value_res = rsp_value_ff;
   assign rsp_last_res  = rsp_last_ff;
   assign rsp_overflow  = rsp_ovf_ff;

   a_emit_into_free_slot: assert property (@(posedge clock) disable iff (reset)
      (op == OP_EMIT_LD) |-> !rsp_valid_ff)
      else $error("result register overwritten while a beat was pending");

   a_loaded_bounded: assert property (@(posedge clock) disable iff (reset)
      loaded_ff <= DEPTH_POS)
      else $error("element count exceeds storage depth");

   a_drop_only_when_full: assert property (@(posedge clock) disable iff (reset)
      dropped_ff |-> full)
      else $error("drop flag set while storage had room");

   a_move_goes_down: assert property (@(posedge clock) disable iff (reset)
      (op == OP_MOVE) |-> ((bidx_ff > i_ff) && (bidx_ff <= extent_ff)))
      else $error("sift step moved outside the heap");

endmodule

[sv/heap_sort_engine_unit.sv]
// Top level of the heap sort engine: sequencer, datapath and element RAM.
//
//   Channel  Ports                                   Direction  Beat
//   ------   --------------------------------------  ---------  -----------------------------
//   req      req_valid/req_ready, value, last        in         one element to store
//   rsp      rsp_valid/rsp_ready, value_res, flags   out        one element of the result set
//   csr      psel/penable/pwrite/paddr/pwdata/...    in/out     mode register at address 0
//
// Request beats are accepted while the engine is idle. The beat flagged last starts the work:
// the heap build and, in sort mode, the extraction loop walk the heap one level at a time, and
// every key goes through the single read port of the element RAM; the result beats of the
// set are sent once that work is done.
// Reset is synchronous and clears the element count, heap extent, drop flag, mode and the
// result valid flag; the element RAM is not cleared, since only positions written by the
// current set are read.
// A stalled result beat holds the sequencer before the next RAM read; once the final
// beat of a set sits in the result register, new request beats are accepted again.
module heap_sort_engine_unit
   import hse_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   // Request channel.
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic signed [DATA_W-1:0] req_value,
   input  logic                     req_last,
   // Result channel.
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [DATA_W-1:0] rsp_value_res,
   output logic                     rsp_last_res,
   output logic                     rsp_overflow,
   // Configuration port.
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_AW-1:0]        paddr,
   input  logic [CSR_DW-1:0]        pwdata,
   output logic [CSR_DW-1:0]        prdata,
   output logic                     pready
);

   // Command and status between the sequencer and the datapath.
   hse_op_type   op;
   hse_stat_type stat;

   // Element RAM connections; position p of the heap lives at address p-1.
   logic                     ram_wr_en;
   logic [ADDR_W-1:0]        ram_wr_addr;
   logic [DATA_W-1:0]        ram_wr_data;
   logic                     ram_rd_en;
   logic [ADDR_W-1:0]        ram_rd_addr;
   logic [DATA_W-1:0]        ram_rd_data;

   hse_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_last  (req_last),
      .req_ready (req_ready),
      .stat      (stat),
      .op        (op)
   );

   hse_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .op            (op),
      .req_value     (req_value),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .prdata        (prdata),
      .pready        (pready),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_value_res (rsp_value_res),
      .rsp_last_res  (rsp_last_res),
      .rsp_overflow  (rsp_overflow),
      .ram_wr_en     (ram_wr_en),
      .ram_wr_addr   (ram_wr_addr),
      .ram_wr_data   (ram_wr_data),
      .ram_rd_en     (ram_rd_en),
      .ram_rd_addr   (ram_rd_addr),
      .ram_rd_data   (ram_rd_data),
      .stat          (stat)
   );

   // The stored elements of the current set.
   hse_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

endmodule
